FILE: rtl/svt_pkg.sv
// sorted value table: shared constants, codes and controller/datapath interface types
`timescale 1ns / 1ps

package svt_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int KEY_W    = 32;
   localparam int POS_W    = 6;
   localparam int COUNT_W  = 7;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_SEARCH = 2'd1,
      MODE_REMOVE = 2'd2,
      MODE_CLEAR  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      RD_IDX,
      RD_IDX_M1,
      RD_IDX_M2,
      RD_IDX_P1,
      RD_IDX_P2
   } raddr_sel_type;

   typedef struct packed {
      logic          key_load;
      logic          idx_load_zero;
      logic          idx_load_fill;
      logic          idx_inc;
      logic          idx_dec;
      logic          fill_inc;
      logic          fill_dec;
      logic          fill_clear;
      logic          pos_clear;
      logic          pos_capture;
      logic          mem_we;
      logic          wsel_key;
      raddr_sel_type raddr_sel;
      logic          out_load;
      status_type    out_status;
      logic          out_found;
   } cmd_type;

   typedef struct packed {
      logic is_full;
      logic is_empty;
      logic idx_zero;
      logic idx_one;
      logic rd_ge_key;
      logic rd_eq_key;
      logic next_is_fill;
      logic next_below_fill;
      logic out_free;
   } stat_type;

endpackage

FILE: rtl/sorted_value_table_top.sv
// sorted value table top level: stream ports around controller and datapath
`timescale 1ns / 1ps

// Holds up to 64 signed 32-bit values in ascending order (duplicates kept) in a
// single ram with one write and one registered read port, so inserts, searches
// and removes walk the table one entry per cycle. Insert walks down from the
// top, moving each entry not below the key up a slot; remove scans to the
// first match, then pulls the rest down. One request is worked at a time;
// req_tready rises again as soon as the result is in the output register, so
// the next request can start while that result waits. A request whose result
// finds the output register still occupied holds in its last state until that
// result is taken. No clearing pass after reset: entries beyond the fill level
// are never used.

module sorted_value_table_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,    // mode[1:0], key[33:2], zero[39:34]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata     // status[1:0], found[2], position[8:3],
                                     // entry_count[15:9], is_empty[16], zero[23:17]
);

   svt_pkg::cmd_type              cmd;
   svt_pkg::stat_type             stat;
   logic [1:0]                    rsp_status;
   logic                          rsp_found;
   logic [svt_pkg::POS_W-1:0]     rsp_position;
   logic [svt_pkg::COUNT_W-1:0]   rsp_entry_count;
   logic                          rsp_is_empty;
   svt_pkg::mode_type             req_mode;
   logic signed [svt_pkg::KEY_W-1:0] req_key;

   assign req_mode = svt_pkg::mode_type'(req_tdata[1:0]);
   assign req_key  = $signed(req_tdata[33:2]);

   svt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_mode  (req_mode),
      .stat      (stat),
      .cmd       (cmd)
   );

   svt_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_key         (req_key),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_status      (rsp_status),
      .rsp_found       (rsp_found),
      .rsp_position    (rsp_position),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty)
   );

   assign rsp_tdata = {7'd0, rsp_is_empty, rsp_entry_count, rsp_position, rsp_found, rsp_status};

endmodule

FILE: rtl/svt_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module svt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/svt_datapath.sv
// sorted value table datapath: entry ram, index and fill counters, result register
`timescale 1ns / 1ps

module svt_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  logic signed [svt_pkg::KEY_W-1:0] req_key,
   input  svt_pkg::cmd_type                cmd,
   output svt_pkg::stat_type               stat,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_status,
   output logic                            rsp_found,
   output logic [svt_pkg::POS_W-1:0]       rsp_position,
   output logic [svt_pkg::COUNT_W-1:0]     rsp_entry_count,
   output logic                            rsp_is_empty
);

   localparam int IDX_W = svt_pkg::IDX_W;
   localparam int CNT_W = svt_pkg::CNT_W;
   localparam int KEY_W = svt_pkg::KEY_W;

   logic signed [KEY_W-1:0] key_ff, key_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [CNT_W-1:0]        fill_ff, fill_in;
   logic [IDX_W-1:0]        pos_ff, pos_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [1:0]                       status_ff, status_in;
   logic                             found_ff, found_in;
   logic [svt_pkg::POS_W-1:0]        position_ff, position_in;
   logic [svt_pkg::COUNT_W-1:0]      count_ff, count_in;
   logic                             empty_ff, empty_in;

   logic [KEY_W-1:0] rd_data;
   logic [KEY_W-1:0] wdata;
   logic [IDX_W-1:0] raddr;
   logic [CNT_W-1:0] idx_next;
   logic [31:0]      pos_wide;
   logic [31:0]      count_wide;

   svt_ram #(
      .WIDTH (KEY_W),
      .DEPTH (svt_pkg::CAPACITY)
   ) u_ram (
      .clock (clock),
      .we    (cmd.mem_we),
      .waddr (idx_ff),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rd_data)
   );

   assign wdata = cmd.wsel_key ? key_ff : rd_data;

   always_comb begin
      unique case (cmd.raddr_sel)
         svt_pkg::RD_IDX:    raddr = idx_ff;
         svt_pkg::RD_IDX_M1: raddr = idx_ff - IDX_W'(1);
         svt_pkg::RD_IDX_M2: raddr = idx_ff - IDX_W'(2);
         svt_pkg::RD_IDX_P1: raddr = idx_ff + IDX_W'(1);
         svt_pkg::RD_IDX_P2: raddr = idx_ff + IDX_W'(2);
         default:            raddr = idx_ff;
      endcase
   end

   assign idx_next = CNT_W'(idx_ff) + CNT_W'(1);

   always_comb begin
      stat.is_full         = (fill_ff == CNT_W'(svt_pkg::CAPACITY));
      stat.is_empty        = (fill_ff == '0);
      stat.idx_zero        = (idx_ff == '0);
      stat.idx_one         = (idx_ff == IDX_W'(1));
      stat.rd_ge_key       = ($signed(rd_data) >= key_ff);
      stat.rd_eq_key       = (rd_data == key_ff);
      stat.next_is_fill    = (idx_next == fill_ff);
      stat.next_below_fill = (idx_next < fill_ff);
      stat.out_free        = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      key_in = cmd.key_load ? req_key : key_ff;

      idx_in = idx_ff;
      if (cmd.idx_load_zero) begin
         idx_in = '0;
      end else if (cmd.idx_load_fill) begin
         idx_in = fill_ff[IDX_W-1:0];
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + IDX_W'(1);
      end else if (cmd.idx_dec) begin
         idx_in = idx_ff - IDX_W'(1);
      end

      fill_in = fill_ff;
      if (cmd.fill_clear) begin
         fill_in = '0;
      end else if (cmd.fill_inc) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (cmd.fill_dec) begin
         fill_in = fill_ff - CNT_W'(1);
      end

      pos_in = pos_ff;
      if (cmd.pos_clear) begin
         pos_in = '0;
      end else if (cmd.pos_capture) begin
         pos_in = idx_ff;
      end
   end

   // result register: the next request may run while a result waits here
   always_comb begin
      pos_wide   = 32'(pos_ff);
      count_wide = 32'(fill_ff);

      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      position_in  = position_ff;
      count_in     = count_ff;
      empty_in     = empty_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         status_in    = cmd.out_status;
         found_in     = cmd.out_found;
         position_in  = pos_wide[svt_pkg::POS_W-1:0];
         count_in     = count_wide[svt_pkg::COUNT_W-1:0];
         empty_in     = stat.is_empty;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff      <= key_in;
      idx_ff      <= idx_in;
      pos_ff      <= pos_in;
      status_ff   <= status_in;
      found_ff    <= found_in;
      position_ff <= position_in;
      count_ff    <= count_in;
      empty_ff    <= empty_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_found       = found_ff;
   assign rsp_position    = position_ff;
   assign rsp_entry_count = count_ff;
   assign rsp_is_empty    = empty_ff;

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(svt_pkg::CAPACITY))
      else $error("fill level above capacity");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_we |-> (CNT_W'(idx_ff) <= fill_ff))
      else $error("entry write beyond fill level");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten before transfer");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.fill_clear |=> (fill_ff == '0))
      else $error("clear left entries in table");

endmodule

FILE: rtl/svt_ctrl.sv
// sorted value table controller: sequences scan, shift and result load
`timescale 1ns / 1ps

module svt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  svt_pkg::mode_type  req_mode,
   input  svt_pkg::stat_type  stat,
   output svt_pkg::cmd_type   cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_DEL,
      ST_FINISH
   } state_type;

   state_type            state_ff, state_in;
   svt_pkg::mode_type    mode_ff, mode_in;
   svt_pkg::status_type  status_ff, status_in;
   logic                 found_ff, found_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      status_in = status_ff;
      found_in  = found_ff;
      cmd       = '0;
      cmd.raddr_sel  = svt_pkg::RD_IDX;
      cmd.out_status = status_ff;
      cmd.out_found  = found_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.key_load  = 1'b1;
               cmd.pos_clear = 1'b1;
               mode_in   = req_mode;
               status_in = svt_pkg::STATUS_OK;
               found_in  = 1'b0;
               unique case (req_mode)
                  svt_pkg::MODE_INSERT: begin
                     if (stat.is_full) begin
                        status_in = svt_pkg::STATUS_FULL;
                        state_in  = ST_FINISH;
                     end else begin
                        cmd.idx_load_fill = 1'b1;
                        state_in = ST_INS_RD;
                     end
                  end
                  svt_pkg::MODE_SEARCH, svt_pkg::MODE_REMOVE: begin
                     if (stat.is_empty) begin
                        status_in = svt_pkg::STATUS_NOT_FOUND;
                        state_in  = ST_FINISH;
                     end else begin
                        cmd.idx_load_zero = 1'b1;
                        state_in = ST_SRCH_RD;
                     end
                  end
                  default: begin
                     cmd.fill_clear = 1'b1;
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end

         // insert walks down from the top, moving entries not below the key up one slot
         ST_INS_RD: begin
            if (stat.idx_zero) begin
               cmd.mem_we      = 1'b1;
               cmd.wsel_key    = 1'b1;
               cmd.pos_capture = 1'b1;
               cmd.fill_inc    = 1'b1;
               state_in = ST_FINISH;
            end else begin
               cmd.raddr_sel = svt_pkg::RD_IDX_M1;
               state_in = ST_INS_CMP;
            end
         end

         ST_INS_CMP: begin
            if (stat.rd_ge_key) begin
               cmd.mem_we    = 1'b1;
               cmd.idx_dec   = 1'b1;
               cmd.raddr_sel = svt_pkg::RD_IDX_M2;
               if (stat.idx_one) begin
                  state_in = ST_INS_RD;
               end
            end else begin
               cmd.mem_we      = 1'b1;
               cmd.wsel_key    = 1'b1;
               cmd.pos_capture = 1'b1;
               cmd.fill_inc    = 1'b1;
               state_in = ST_FINISH;
            end
         end

         ST_SRCH_RD: begin
            cmd.raddr_sel = svt_pkg::RD_IDX;
            state_in = ST_SRCH_CMP;
         end

         // read data is the entry at idx, next entry already requested
         ST_SRCH_CMP: begin
            cmd.raddr_sel = svt_pkg::RD_IDX_P1;
            if (stat.rd_eq_key) begin
               cmd.pos_capture = 1'b1;
               found_in = 1'b1;
               state_in = (mode_ff == svt_pkg::MODE_REMOVE) ? ST_DEL : ST_FINISH;
            end else if (stat.next_is_fill) begin
               status_in = svt_pkg::STATUS_NOT_FOUND;
               state_in  = ST_FINISH;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end

         // remove pulls later entries down one slot
         ST_DEL: begin
            cmd.raddr_sel = svt_pkg::RD_IDX_P2;
            if (stat.next_below_fill) begin
               cmd.mem_we  = 1'b1;
               cmd.idx_inc = 1'b1;
            end else begin
               cmd.fill_dec = 1'b1;
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         mode_ff   <= svt_pkg::MODE_INSERT;
         status_ff <= svt_pkg::STATUS_OK;
         found_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         mode_ff   <= mode_in;
         status_ff <= status_in;
         found_ff  <= found_in;
      end
   end

endmodule
